/* rtl/absorbing_graph_walker_assert.svh */
// Assertion macros for the port-level checker.
`ifndef ABSORBING_GRAPH_WALKER_ASSERT_SVH
`define ABSORBING_GRAPH_WALKER_ASSERT_SVH

// Checks cons in the same cycle as ante, outside reset.
`define AGW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks cons in the cycle after ante, outside reset.
`define AGW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Checks cons in the cycle after ante, also through reset.
`define AGW_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/agw_pkg.sv */
// Shared types and constants of the absorbing graph walker.
package agw_pkg;

  localparam int MAX_NODES   = 256;
  localparam int MAX_EDGES   = 1024;
  localparam int MAX_WALKERS = 16;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int EDGE_W = $clog2(MAX_EDGES);
  localparam int WLK_W  = $clog2(MAX_WALKERS);
  localparam int OFF_AW = $clog2(MAX_NODES + 1);
  localparam int EDGE_DW = NODE_W + 2;

  localparam logic [1:0] KIND_LOAD_OFFSET = 2'd0;
  localparam logic [1:0] KIND_LOAD_EDGE   = 2'd1;
  localparam logic [1:0] KIND_START       = 2'd2;
  localparam logic [1:0] KIND_STEP        = 2'd3;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RUN     = 3'd1;
  localparam logic [2:0] ST_COVERED = 3'd2;
  localparam logic [2:0] ST_TRAPPED = 3'd3;
  localparam logic [2:0] ST_DIED    = 3'd4;

  localparam logic CFG_STOP_THRESHOLD = 1'b0;
  localparam logic CFG_TRACK_UNIQUE   = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  index;
    logic [10:0] value;
    logic        kill_edge;
    logic        reflect_edge;
    logic [31:0] random_word;
    logic        wr_ok;
  } item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_START, S_START_NV, S_STEP, S_OFF_A, S_OFF_B, S_OFF_C,
    S_SCAN_RD, S_SCAN_CHK, S_DIV, S_EDGE_RD, S_EDGE_D, S_UPDATE, S_NV_RD,
    S_NV_D, S_OUT
  } state_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

endpackage

/* rtl/absorbing_graph_walker.sv */
// Top level of the absorbing graph walker.
// Items enter through push/full and are taken when push is high and full
// is low. Results leave through empty/pop: the oldest result sits on the
// result ports while empty is low and is taken when pop is high.
// Configuration registers are written with cfg_write, cfg_index and
// cfg_data at a clock edge. The user must write them only while the
// block is idle; the block itself does not enforce this.
// A two-entry input queue lets items arrive while earlier ones are worked.
// The sequencer in the back end works one item at a time: a load writes
// its table; a start sets up the walker and, unless it is covered at
// once, reads the node's offsets and scans its edges; a running step
// reads the offsets, picks an edge with the serial divider, then reads
// it and updates the walker; other steps end by reading the visit count.
// Each item gives one result held in an output register; while the
// receiver does not pop, the sequencer holds its next result and the
// input queue fills and then raises full.
// Reset clears all walkers and visit counts, sets stop_threshold to 256
// and turns unique tracking on; the adjacency table must be loaded first.
module absorbing_graph_walker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [9:0]  index,
  input  logic [10:0] value,
  input  logic        kill_edge,
  input  logic        reflect_edge,
  input  logic [31:0] random_word,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  walker,
  output logic [7:0]  position,
  output logic [31:0] step_count,
  output logic [8:0]  unique_count,
  output logic [31:0] visit_count,
  output logic [2:0]  status,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);
  agw_pkg::item_t head;
  logic           q_empty;
  logic           q_pop;
  logic [8:0]     stop_threshold;
  logic           unique_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_threshold <= 9'd256;
      unique_en <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        agw_pkg::CFG_STOP_THRESHOLD: stop_threshold <= cfg_data;
        agw_pkg::CFG_TRACK_UNIQUE:   unique_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  agw_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind), .index(index),
    .value(value), .kill_edge(kill_edge), .reflect_edge(reflect_edge),
    .random_word(random_word), .head(head), .q_empty(q_empty), .q_pop(q_pop));

  agw_back u_back (
    .clk(clk), .rst(rst), .head(head), .q_empty(q_empty), .q_pop(q_pop),
    .stop_threshold(stop_threshold), .unique_en(unique_en),
    .empty(empty), .pop(pop), .walker(walker), .position(position),
    .step_count(step_count), .unique_count(unique_count),
    .visit_count(visit_count), .status(status));
endmodule

/* rtl/agw_ram.sv */
// Generic single write port RAM with registered read.
module agw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/agw_front.sv */
// Front end: accepts items, classifies load writes and queues them.
module agw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        kind,
  input  logic [9:0]        index,
  input  logic [10:0]       value,
  input  logic              kill_edge,
  input  logic              reflect_edge,
  input  logic [31:0]       random_word,
  output agw_pkg::item_t    head,
  output logic              q_empty,
  input  logic              q_pop
);
  agw_pkg::item_t slots [2];
  agw_pkg::item_t item_in;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    item_in.kind = kind;
    item_in.index = index;
    item_in.value = value;
    item_in.kill_edge = kill_edge;
    item_in.reflect_edge = reflect_edge;
    item_in.random_word = random_word;
    if (kind == agw_pkg::KIND_LOAD_OFFSET) begin
      item_in.wr_ok = ({1'b0, index} <= 11'(agw_pkg::MAX_NODES));
    end else begin
      item_in.wr_ok = ({1'b0, index} < 11'(agw_pkg::MAX_EDGES));
    end
  end

  assign full = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign head = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule

/* rtl/agw_back.sv */
// Back end: sequencer that carries out loads, starts and steps.
module agw_back (
  input  logic                 clk,
  input  logic                 rst,
  input  agw_pkg::item_t       head,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic [8:0]           stop_threshold,
  input  logic                 unique_en,
  output logic                 empty,
  input  logic                 pop,
  output logic [3:0]           walker,
  output logic [7:0]           position,
  output logic [31:0]          step_count,
  output logic [8:0]           unique_count,
  output logic [31:0]          visit_count,
  output logic [2:0]           status
);
  localparam int NW = agw_pkg::NODE_W;
  localparam int WW = agw_pkg::WLK_W;

  agw_pkg::state_t state, state_next;
  agw_pkg::item_t  cur;

  logic [NW-1:0] wpos   [agw_pkg::MAX_WALKERS];
  logic [31:0]   wsteps [agw_pkg::MAX_WALKERS];
  logic [8:0]    wuniq  [agw_pkg::MAX_WALKERS];
  logic [2:0]    wstat  [agw_pkg::MAX_WALKERS];
  logic [agw_pkg::MAX_WALKERS-1:0] vis_valid;
  logic [agw_pkg::MAX_NODES-1:0]   nv_valid;

  logic [WW-1:0] w_r;
  logic [NW-1:0] pos_r;
  logic [10:0]   beg_r;
  logic [10:0]   deg_r;
  logic [10:0]   cnt;
  logic [10:0]   rem_r;
  logic [31:0]   dvd_r;
  logic [31:0]   visit_r;
  logic          kill_r;
  logic          out_valid;

  logic                         off_we;
  logic [agw_pkg::OFF_AW-1:0]   off_raddr;
  logic [10:0]                  off_rdata;
  logic                         edge_we;
  logic [agw_pkg::EDGE_W-1:0]   edge_raddr;
  logic [agw_pkg::EDGE_DW-1:0]  edge_rdata;
  logic                         nv_we;
  logic [NW-1:0]                nv_raddr;
  logic [31:0]                  nv_rdata;
  logic                         vis_we;
  logic [agw_pkg::MAX_NODES-1:0] vis_wdata;
  logic [agw_pkg::MAX_NODES-1:0] vis_rdata;

  logic [31:0]   nvv;
  logic [31:0]   nv_inc;
  logic [10:0]   deg_c;
  logic [11:0]   rem2;
  logic [10:0]   rem_n;
  logic [NW-1:0] np_c;
  logic [agw_pkg::MAX_NODES-1:0] row;
  logic [agw_pkg::MAX_NODES-1:0] pos_hot;
  logic [agw_pkg::MAX_NODES-1:0] start_hot;
  logic          new_bit;
  logic [8:0]    uniq_n;
  logic [8:0]    uniq_start;
  logic          e_kill;
  logic          e_refl;

  agw_ram #(.WIDTH(11), .DEPTH(agw_pkg::MAX_NODES + 1)) u_offsets (
    .clk(clk), .we(off_we), .waddr(cur.index[agw_pkg::OFF_AW-1:0]),
    .wdata(cur.value), .raddr(off_raddr), .rdata(off_rdata));

  agw_ram #(.WIDTH(agw_pkg::EDGE_DW), .DEPTH(agw_pkg::MAX_EDGES)) u_edges (
    .clk(clk), .we(edge_we), .waddr(cur.index[agw_pkg::EDGE_W-1:0]),
    .wdata({cur.value[NW-1:0], cur.kill_edge, cur.reflect_edge}),
    .raddr(edge_raddr), .rdata(edge_rdata));

  agw_ram #(.WIDTH(32), .DEPTH(agw_pkg::MAX_NODES)) u_visits (
    .clk(clk), .we(nv_we), .waddr(pos_r), .wdata(nv_inc),
    .raddr(nv_raddr), .rdata(nv_rdata));

  agw_ram #(.WIDTH(agw_pkg::MAX_NODES), .DEPTH(agw_pkg::MAX_WALKERS)) u_visited (
    .clk(clk), .we(vis_we), .waddr(w_r), .wdata(vis_wdata),
    .raddr(w_r), .rdata(vis_rdata));

  assign e_kill = edge_rdata[1];
  assign e_refl = edge_rdata[0];
  assign nvv = nv_valid[pos_r] ? nv_rdata : 32'd0;
  assign nv_inc = agw_pkg::sat_inc(nvv);
  assign deg_c = (off_rdata > beg_r) ? off_rdata - beg_r : 11'd0;
  assign rem2 = {rem_r, dvd_r[31]};
  assign rem_n = (rem2 >= {1'b0, deg_r}) ? 11'(rem2 - {1'b0, deg_r}) : rem2[10:0];
  assign np_c = e_refl ? pos_r : edge_rdata[agw_pkg::EDGE_DW-1:2];
  assign row = vis_valid[w_r] ? vis_rdata : '0;
  assign pos_hot = {{(agw_pkg::MAX_NODES-1){1'b0}}, 1'b1} << pos_r;
  assign start_hot = {{(agw_pkg::MAX_NODES-1){1'b0}}, 1'b1} << cur.value[NW-1:0];
  assign new_bit = unique_en && !row[pos_r];
  assign uniq_n = (new_bit && wuniq[w_r] != 9'h1FF) ? wuniq[w_r] + 9'd1 : wuniq[w_r];
  assign uniq_start = unique_en ? 9'd1 : 9'd0;
  assign empty = !out_valid;

  always_comb begin
    off_we = (state == agw_pkg::S_LOAD) && cur.kind == agw_pkg::KIND_LOAD_OFFSET
             && cur.wr_ok;
    edge_we = (state == agw_pkg::S_LOAD) && cur.kind == agw_pkg::KIND_LOAD_EDGE
              && cur.wr_ok;
    nv_we = (state == agw_pkg::S_START_NV) || (state == agw_pkg::S_UPDATE);
    vis_we = (state == agw_pkg::S_START) || (state == agw_pkg::S_UPDATE);
    vis_wdata = (state == agw_pkg::S_START) ? (unique_en ? start_hot : '0)
                                            : (row | (new_bit ? pos_hot : '0));
    off_raddr = (state == agw_pkg::S_OFF_B) ? {1'b0, pos_r} + 9'd1 : {1'b0, pos_r};
    if (state == agw_pkg::S_EDGE_RD) begin
      edge_raddr = 10'(beg_r + rem_r);
    end else begin
      edge_raddr = 10'(beg_r + cnt);
    end
    if (state == agw_pkg::S_START) begin
      nv_raddr = cur.value[NW-1:0];
    end else if (state == agw_pkg::S_EDGE_D) begin
      nv_raddr = np_c;
    end else begin
      nv_raddr = pos_r;
    end
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    case (state)
      agw_pkg::S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (head.kind)
            agw_pkg::KIND_START: state_next = agw_pkg::S_START;
            agw_pkg::KIND_STEP:  state_next = agw_pkg::S_STEP;
            default:             state_next = agw_pkg::S_LOAD;
          endcase
        end
      end
      agw_pkg::S_LOAD:     state_next = agw_pkg::S_OUT;
      agw_pkg::S_START:    state_next = agw_pkg::S_START_NV;
      agw_pkg::S_START_NV: begin
        if (unique_en && wuniq[w_r] >= stop_threshold) begin
          state_next = agw_pkg::S_OUT;
        end else begin
          state_next = agw_pkg::S_OFF_A;
        end
      end
      agw_pkg::S_STEP: begin
        if (wstat[w_r] != agw_pkg::ST_RUN) begin
          state_next = agw_pkg::S_NV_RD;
        end else begin
          state_next = agw_pkg::S_OFF_A;
        end
      end
      agw_pkg::S_OFF_A: state_next = agw_pkg::S_OFF_B;
      agw_pkg::S_OFF_B: state_next = agw_pkg::S_OFF_C;
      agw_pkg::S_OFF_C: begin
        if (cur.kind == agw_pkg::KIND_START) begin
          state_next = (deg_c == 11'd0) ? agw_pkg::S_OUT : agw_pkg::S_SCAN_RD;
        end else begin
          state_next = (deg_c == 11'd0) ? agw_pkg::S_NV_RD : agw_pkg::S_DIV;
        end
      end
      agw_pkg::S_SCAN_RD: state_next = agw_pkg::S_SCAN_CHK;
      agw_pkg::S_SCAN_CHK: begin
        if (!e_refl || e_kill || cnt + 11'd1 == deg_r) begin
          state_next = agw_pkg::S_OUT;
        end else begin
          state_next = agw_pkg::S_SCAN_RD;
        end
      end
      agw_pkg::S_DIV: begin
        if (cnt == 11'd31) begin
          state_next = agw_pkg::S_EDGE_RD;
        end
      end
      agw_pkg::S_EDGE_RD: state_next = agw_pkg::S_EDGE_D;
      agw_pkg::S_EDGE_D:  state_next = agw_pkg::S_UPDATE;
      agw_pkg::S_UPDATE:  state_next = agw_pkg::S_OUT;
      agw_pkg::S_NV_RD:   state_next = agw_pkg::S_NV_D;
      agw_pkg::S_NV_D:    state_next = agw_pkg::S_OUT;
      agw_pkg::S_OUT: begin
        if (!out_valid || pop) begin
          state_next = agw_pkg::S_IDLE;
        end
      end
      default: state_next = agw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= agw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      vis_valid <= '0;
      nv_valid <= '0;
      for (int i = 0; i < agw_pkg::MAX_WALKERS; i++) begin
        wpos[i] <= '0;
        wsteps[i] <= '0;
        wuniq[i] <= '0;
        wstat[i] <= agw_pkg::ST_IDLE;
      end
    end else begin
      if (state == agw_pkg::S_OUT && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        agw_pkg::S_IDLE: begin
          if (!q_empty) begin
            cur <= head;
            w_r <= head.index[WW-1:0];
          end
        end
        agw_pkg::S_START: begin
          pos_r <= cur.value[NW-1:0];
          wpos[w_r] <= cur.value[NW-1:0];
          wsteps[w_r] <= '0;
          wstat[w_r] <= agw_pkg::ST_RUN;
          wuniq[w_r] <= uniq_start;
          vis_valid[w_r] <= 1'b1;
        end
        agw_pkg::S_START_NV: begin
          nv_valid[pos_r] <= 1'b1;
          visit_r <= nv_inc;
          if (unique_en && wuniq[w_r] >= stop_threshold) begin
            wstat[w_r] <= agw_pkg::ST_COVERED;
          end
        end
        agw_pkg::S_STEP:  pos_r <= wpos[w_r];
        agw_pkg::S_OFF_B: beg_r <= off_rdata;
        agw_pkg::S_OFF_C: begin
          deg_r <= deg_c;
          cnt <= '0;
          rem_r <= '0;
          dvd_r <= cur.random_word;
          if (cur.kind == agw_pkg::KIND_STEP && deg_c == 11'd0) begin
            wstat[w_r] <= agw_pkg::ST_TRAPPED;
          end
        end
        agw_pkg::S_SCAN_CHK: begin
          cnt <= cnt + 11'd1;
          if (e_refl && !e_kill && cnt + 11'd1 == deg_r) begin
            wstat[w_r] <= agw_pkg::ST_TRAPPED;
          end
        end
        agw_pkg::S_DIV: begin
          rem_r <= rem_n;
          dvd_r <= {dvd_r[30:0], 1'b0};
          cnt <= cnt + 11'd1;
        end
        agw_pkg::S_EDGE_D: begin
          pos_r <= np_c;
          kill_r <= e_kill;
        end
        agw_pkg::S_UPDATE: begin
          nv_valid[pos_r] <= 1'b1;
          visit_r <= nv_inc;
          wsteps[w_r] <= agw_pkg::sat_inc(wsteps[w_r]);
          wuniq[w_r] <= uniq_n;
          wpos[w_r] <= pos_r;
          if (unique_en && uniq_n >= stop_threshold) begin
            wstat[w_r] <= agw_pkg::ST_COVERED;
          end else if (kill_r) begin
            wstat[w_r] <= agw_pkg::ST_DIED;
          end
        end
        agw_pkg::S_NV_D: visit_r <= nvv;
        agw_pkg::S_OUT: begin
          if (!out_valid || pop) begin
            if (cur.kind == agw_pkg::KIND_START || cur.kind == agw_pkg::KIND_STEP) begin
              walker <= 4'(w_r);
              position <= 8'(wpos[w_r]);
              step_count <= wsteps[w_r];
              unique_count <= wuniq[w_r];
              visit_count <= visit_r;
              status <= wstat[w_r];
            end else begin
              walker <= '0;
              position <= '0;
              step_count <= '0;
              unique_count <= '0;
              visit_count <= '0;
              status <= agw_pkg::ST_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* rtl/agw_checker.sv */
// Port-level checker of the absorbing graph walker and its bind.
`include "absorbing_graph_walker_assert.svh"

module agw_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  position,
  input logic [31:0] step_count,
  input logic [8:0]  unique_count,
  input logic [31:0] visit_count,
  input logic [2:0]  status
);
  `AGW_ASSERT_ALWAYS(a_reset_empty, rst, empty, "Result waiting after reset.")
  `AGW_ASSERT_NOW(a_status_code, !empty, status <= agw_pkg::ST_DIED, "Bad status code.")
  `AGW_ASSERT_NOW(a_idle_zero, !empty && status == agw_pkg::ST_IDLE, position == 8'd0 && step_count == 32'd0 && unique_count == 9'd0, "Idle result not zero.")
  `AGW_ASSERT_NOW(a_run_visited, !empty && status == agw_pkg::ST_RUN, visit_count != 32'd0, "Running walker on unvisited node.")
  `AGW_ASSERT_NEXT(a_result_held, !empty && !pop, !empty, "Result dropped without pop.")
endmodule

bind absorbing_graph_walker agw_checker u_agw_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .position(position),
  .step_count(step_count), .unique_count(unique_count),
  .visit_count(visit_count), .status(status));

/* verif/absorbing_graph_walker_tb.sv */
// Testbench for absorbing_graph_walker: random walks checked against a built-in walk tracker.
`timescale 1ns / 1ps

module absorbing_graph_walker_tb;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int WRAP_BASE = 1016;

  typedef struct {
    logic [1:0]  kind;
    logic [9:0]  index;
    logic [10:0] value;
    logic        kill_edge;
    logic        reflect_edge;
    logic [31:0] random_word;
  } walk_item_t;

  typedef struct packed {
    logic [3:0]  walker;
    logic [7:0]  position;
    logic [31:0] step_count;
    logic [8:0]  unique_count;
    logic [31:0] visit_count;
    logic [2:0]  status;
  } walk_report_t;

  class walk_tracker;
    logic [10:0] offs[agw_pkg::MAX_NODES + 1];
    logic [7:0]  tgt[agw_pkg::MAX_EDGES];
    logic        kills[agw_pkg::MAX_EDGES];
    logic        reflects[agw_pkg::MAX_EDGES];
    logic [7:0]  pos[agw_pkg::MAX_WALKERS];
    logic [31:0] steps[agw_pkg::MAX_WALKERS];
    logic [8:0]  uniq[agw_pkg::MAX_WALKERS];
    logic [2:0]  state[agw_pkg::MAX_WALKERS];
    bit          visited[agw_pkg::MAX_WALKERS][agw_pkg::MAX_NODES];
    logic [31:0] visits[agw_pkg::MAX_NODES];
    logic [8:0]  threshold;
    logic        tracking;
    walk_report_t expected_walks[$];
    int errors;
    int checked;
    int status_seen[8];

    function new();
      foreach (offs[i]) offs[i] = '0;
      foreach (tgt[i]) begin
        tgt[i] = '0;
        kills[i] = 1'b0;
        reflects[i] = 1'b0;
      end
      foreach (pos[i]) begin
        pos[i] = '0;
        steps[i] = '0;
        uniq[i] = '0;
        state[i] = agw_pkg::ST_IDLE;
      end
      foreach (visited[i, j]) visited[i][j] = 1'b0;
      foreach (visits[i]) visits[i] = '0;
      threshold = 9'd256;
      tracking = 1'b1;
      errors = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function logic [31:0] bump(logic [31:0] x);
      return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
    endfunction

    function void set_register(logic idx, logic [8:0] data);
      if (idx == agw_pkg::CFG_STOP_THRESHOLD) threshold = data;
      else tracking = data[0];
    endfunction

    function void start_walk(int w, int p);
      int unsigned b, en, deg, e;
      bit refl_only, kill_seen;
      pos[w] = 8'(p);
      steps[w] = '0;
      state[w] = agw_pkg::ST_RUN;
      for (int n = 0; n < agw_pkg::MAX_NODES; n++) visited[w][n] = 1'b0;
      if (tracking) begin
        visited[w][p] = 1'b1;
        uniq[w] = 9'd1;
      end else begin
        uniq[w] = 9'd0;
      end
      visits[p] = bump(visits[p]);
      if (tracking && uniq[w] >= threshold) begin
        state[w] = agw_pkg::ST_COVERED;
        return;
      end
      b = offs[p];
      en = offs[p + 1];
      deg = (en > b) ? en - b : 0;
      refl_only = deg > 0;
      kill_seen = 1'b0;
      for (int unsigned i = 0; i < deg; i++) begin
        e = (b + i) % agw_pkg::MAX_EDGES;
        if (!reflects[e]) refl_only = 1'b0;
        if (kills[e]) kill_seen = 1'b1;
      end
      if (refl_only && !kill_seen) state[w] = agw_pkg::ST_TRAPPED;
    endfunction

    function void step_walk(int w, logic [31:0] rnd);
      int unsigned v, b, en, deg, e, np;
      bit killed;
      v = pos[w];
      if (state[w] != agw_pkg::ST_RUN) return;
      b = offs[v];
      en = offs[v + 1];
      deg = (en > b) ? en - b : 0;
      if (deg == 0) begin
        state[w] = agw_pkg::ST_TRAPPED;
        return;
      end
      e = (b + rnd % deg) % agw_pkg::MAX_EDGES;
      killed = kills[e];
      np = reflects[e] ? v : tgt[e];
      steps[w] = bump(steps[w]);
      if (tracking && !visited[w][np]) begin
        visited[w][np] = 1'b1;
        if (uniq[w] != 9'h1FF) uniq[w] = uniq[w] + 9'd1;
      end
      visits[np] = bump(visits[np]);
      pos[w] = 8'(np);
      if (tracking && uniq[w] >= threshold) state[w] = agw_pkg::ST_COVERED;
      else if (killed) state[w] = agw_pkg::ST_DIED;
    endfunction

    function void note_item(walk_item_t it);
      walk_report_t r;
      int w;
      r = '0;
      if (it.kind == agw_pkg::KIND_LOAD_OFFSET) begin
        if (it.index <= agw_pkg::MAX_NODES) offs[it.index] = it.value;
      end else if (it.kind == agw_pkg::KIND_LOAD_EDGE) begin
        tgt[it.index] = it.value[7:0];
        kills[it.index] = it.kill_edge;
        reflects[it.index] = it.reflect_edge;
      end else begin
        w = it.index % agw_pkg::MAX_WALKERS;
        if (it.kind == agw_pkg::KIND_START) start_walk(w, it.value % agw_pkg::MAX_NODES);
        else step_walk(w, it.random_word);
        r.walker = 4'(w);
        r.position = pos[w];
        r.step_count = steps[w];
        r.unique_count = uniq[w];
        r.visit_count = visits[pos[w]];
        r.status = state[w];
      end
      expected_walks.push_back(r);
    endfunction

    function void check_result(walk_report_t got);
      walk_report_t want;
      if (expected_walks.size() == 0) begin
        if (errors < 10) $display("Result arrived with no item outstanding: status %0d",
                                  got.status);
        errors++;
        return;
      end
      want = expected_walks.pop_front();
      checked++;
      status_seen[got.status]++;
      if (got !== want) begin
        if (errors < 10) begin
          $display("Mismatch at result %0d: expected w%0d p%0d s%0d u%0d v%0d st%0d,",
                   checked, want.walker, want.position, want.step_count,
                   want.unique_count, want.visit_count, want.status);
          $display("  got w%0d p%0d s%0d u%0d v%0d st%0d",
                   got.walker, got.position, got.step_count, got.unique_count,
                   got.visit_count, got.status);
        end
        errors++;
      end
    endfunction

    function int pending();
      return expected_walks.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  kind;
  logic [9:0]  index;
  logic [10:0] value;
  logic        kill_edge;
  logic        reflect_edge;
  logic [31:0] random_word;
  logic        empty;
  logic        pop;
  logic [3:0]  walker;
  logic [7:0]  position;
  logic [31:0] step_count;
  logic [8:0]  unique_count;
  logic [31:0] visit_count;
  logic [2:0]  status;
  logic        cfg_write;
  logic        cfg_index;
  logic [8:0]  cfg_data;

  walk_tracker tracker;
  bit quiet;
  bit hold_request;
  int cycles = 0;
  int edge_top;
  int kind_count[4];

  absorbing_graph_walker dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind), .index(index),
    .value(value), .kill_edge(kill_edge), .reflect_edge(reflect_edge),
    .random_word(random_word), .empty(empty), .pop(pop), .walker(walker),
    .position(position), .step_count(step_count), .unique_count(unique_count),
    .visit_count(visit_count), .status(status), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               tracker.pending());
      $display("** absorbing_graph_walker: FAILED **");
      $finish;
    end
  end

  function automatic walk_item_t make_item(logic [1:0] k, logic [9:0] idx, logic [10:0] val,
                                           logic kl, logic rf, logic [31:0] rnd);
    walk_item_t it;
    it.kind = k;
    it.index = idx;
    it.value = val;
    it.kill_edge = kl;
    it.reflect_edge = rf;
    it.random_word = rnd;
    return it;
  endfunction

  task automatic send_item(walk_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push = 1'b1;
    kind = it.kind;
    index = it.index;
    value = it.value;
    kill_edge = it.kill_edge;
    reflect_edge = it.reflect_edge;
    random_word = it.random_word;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    tracker.note_item(it);
    kind_count[it.kind]++;
  endtask

  task automatic drain_and_configure(logic [8:0] thr, logic trk);
    @(negedge clk);
    push = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = agw_pkg::CFG_STOP_THRESHOLD;
    cfg_data = thr;
    @(negedge clk);
    cfg_index = agw_pkg::CFG_TRACK_UNIQUE;
    cfg_data = {8'd0, trk};
    @(negedge clk);
    cfg_write = 1'b0;
    tracker.set_register(agw_pkg::CFG_STOP_THRESHOLD, thr);
    tracker.set_register(agw_pkg::CFG_TRACK_UNIQUE, {8'd0, trk});
  endtask

  // Node 0 has no edges, node 1 has only reflecting edges, node 2 wraps past
  // the end of the edge table, and nodes 3 and 150 have offsets out of order.
  task automatic load_graph();
    int unsigned off;
    logic [10:0] offsets[agw_pkg::MAX_NODES + 1];
    offsets[0] = 11'(WRAP_BASE);
    offsets[1] = 11'(WRAP_BASE);
    offsets[2] = 11'(WRAP_BASE + 3);
    offsets[3] = 11'(agw_pkg::MAX_EDGES + 6);
    offsets[4] = 11'd6;
    off = 6;
    edge_top = 6;
    for (int v = 5; v <= agw_pkg::MAX_NODES; v++) begin
      if (v == 151) off = off - 3;
      else off = off + $urandom_range(0, 3);
      offsets[v] = 11'(off);
      if (off > edge_top) edge_top = off;
    end
    for (int v = 0; v <= agw_pkg::MAX_NODES; v++)
      send_item(make_item(agw_pkg::KIND_LOAD_OFFSET, 10'(v), offsets[v], 1'b0, 1'b0,
                          $urandom));
    send_item(make_item(agw_pkg::KIND_LOAD_OFFSET, 10'd1023, 11'd2047, 1'b1, 1'b1, '1));
    send_item(make_item(agw_pkg::KIND_LOAD_OFFSET, 10'd257, 11'd0, 1'b0, 1'b0, '0));
    for (int e = 0; e < agw_pkg::MAX_EDGES; e++) begin
      if (e >= WRAP_BASE && e <= WRAP_BASE + 2)
        send_item(make_item(agw_pkg::KIND_LOAD_EDGE, 10'(e), 11'($urandom_range(0, 2047)),
                            1'b0, 1'b1, $urandom));
      else if (e < edge_top || e >= WRAP_BASE)
        send_item(make_item(agw_pkg::KIND_LOAD_EDGE, 10'(e), 11'($urandom_range(0, 2047)),
                            $urandom_range(0, 11) == 0, $urandom_range(0, 5) == 0,
                            $urandom));
    end
  endtask

  task automatic random_walks(int count);
    int r;
    int slot;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 15)
        send_item(make_item(agw_pkg::KIND_START, 10'($urandom),
                            11'($urandom_range(0, 2047)), 1'($urandom), 1'($urandom),
                            $urandom));
      else if (r < 91)
        send_item(make_item(agw_pkg::KIND_STEP, 10'($urandom), 11'($urandom),
                            1'($urandom), 1'($urandom), $urandom));
      else if (r < 97)
        send_item(make_item(agw_pkg::KIND_LOAD_EDGE, 10'($urandom),
                            11'($urandom_range(0, 2047)), $urandom_range(0, 7) == 0,
                            $urandom_range(0, 5) == 0, $urandom));
      else begin
        if ($urandom_range(0, 3) == 0) slot = $urandom_range(agw_pkg::MAX_NODES + 1, 1023);
        else slot = $urandom_range(5, agw_pkg::MAX_NODES);
        send_item(make_item(agw_pkg::KIND_LOAD_OFFSET, 10'(slot),
                            11'($urandom_range(6, edge_top)), 1'($urandom), 1'($urandom),
                            $urandom));
      end
    end
  endtask

  initial begin
    walk_report_t got;
    int stall;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 13);
        pop = 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop = 1'b1;
      @(posedge clk);
      if (pop && !empty) begin
        got.walker = walker;
        got.position = position;
        got.step_count = step_count;
        got.unique_count = unique_count;
        got.visit_count = visit_count;
        got.status = status;
        tracker.check_result(got);
      end
    end
  end

  initial begin
    tracker = new();
    quiet = 1'b0;
    hold_request = 1'b0;
    edge_top = 6;
    foreach (kind_count[i]) kind_count[i] = 0;
    rst = 1'b1;
    push = 1'b0;
    kind = agw_pkg::KIND_LOAD_OFFSET;
    index = '0;
    value = '0;
    kill_edge = 1'b0;
    reflect_edge = 1'b0;
    random_word = '0;
    cfg_write = 1'b0;
    cfg_index = agw_pkg::CFG_STOP_THRESHOLD;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A step of a walker that was never started reports the idle state.
    send_item(make_item(agw_pkg::KIND_STEP, 10'd7, 11'd0, 1'b0, 1'b0, 32'hFFFF_FFFF));
    drain_and_configure(9'd256, 1'b1);
    load_graph();

    // Directed walks: degree-0 node, start trap, wrapping numbers, stopped walkers.
    send_item(make_item(agw_pkg::KIND_START, 10'd0, 11'd0, 1'b0, 1'b0, '0));
    send_item(make_item(agw_pkg::KIND_STEP, 10'd0, 11'd0, 1'b0, 1'b0, '0));
    send_item(make_item(agw_pkg::KIND_STEP, 10'd0, 11'd0, 1'b0, 1'b0, '1));
    send_item(make_item(agw_pkg::KIND_START, 10'd1, 11'd1, 1'b0, 1'b0, '0));
    send_item(make_item(agw_pkg::KIND_STEP, 10'd17, 11'd0, 1'b0, 1'b0, 32'h1234_5678));
    send_item(make_item(agw_pkg::KIND_START, 10'd1023, 11'd2047, 1'b1, 1'b1, '1));
    send_item(make_item(agw_pkg::KIND_STEP, 10'd15, 11'd0, 1'b0, 1'b0, '1));
    send_item(make_item(agw_pkg::KIND_START, 10'd2, 11'd1024 + 11'd2, 1'b0, 1'b0, '0));
    send_item(make_item(agw_pkg::KIND_STEP, 10'd2, 11'd0, 1'b0, 1'b0, '0));
    send_item(make_item(agw_pkg::KIND_START, 10'd3, 11'd150, 1'b0, 1'b0, '0));
    send_item(make_item(agw_pkg::KIND_STEP, 10'd3, 11'd0, 1'b0, 1'b0, $urandom));
    send_item(make_item(agw_pkg::KIND_START, 10'd4, 11'd254, 1'b0, 1'b0, '0));
    send_item(make_item(agw_pkg::KIND_STEP, 10'd4, 11'd0, 1'b0, 1'b0, $urandom));
    send_item(make_item(agw_pkg::KIND_START, 10'd4, 11'd120, 1'b0, 1'b0, '0));
    send_item(make_item(agw_pkg::KIND_STEP, 10'd4, 11'd0, 1'b0, 1'b0, $urandom));
    send_item(make_item(agw_pkg::KIND_STEP, 10'd4, 11'd0, 1'b0, 1'b0, $urandom));
    random_walks(100);

    drain_and_configure(9'd4, 1'b1);
    hold_request = 1'b1;
    random_walks(100);
    drain_and_configure(9'd0, 1'b1);
    random_walks(60);
    drain_and_configure(9'h1FF, 1'b0);
    random_walks(80);
    drain_and_configure(9'd12, 1'b1);
    random_walks(100);
    drain_and_configure(9'd1, 1'b0);
    quiet = 1'b1;
    random_walks(80);

    @(negedge clk);
    push = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d offset loads, %0d edge loads, %0d starts, %0d steps.",
             tracker.checked, kind_count[agw_pkg::KIND_LOAD_OFFSET],
             kind_count[agw_pkg::KIND_LOAD_EDGE], kind_count[agw_pkg::KIND_START],
             kind_count[agw_pkg::KIND_STEP]);
    $display("Results seen: %0d running, %0d covered, %0d trapped, %0d died; %0d mismatches.",
             tracker.status_seen[agw_pkg::ST_RUN], tracker.status_seen[agw_pkg::ST_COVERED],
             tracker.status_seen[agw_pkg::ST_TRAPPED], tracker.status_seen[agw_pkg::ST_DIED],
             tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("** absorbing_graph_walker: PASSED **");
    end else begin
      $display("** absorbing_graph_walker: FAILED **");
    end
    $finish;
  end

endmodule
